### sv/pdsu_pkg.sv
`default_nettype none
package pdsu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COEF_BITS = 21;
  localparam int ROW_W     = 63;
  localparam int EXP_W     = 6;
  localparam int NUM_REGS  = 8;
  localparam int IDX_W     = $clog2(NUM_REGS);
  localparam int SQ_STEPS  = 4;
  localparam int RM_W      = 63 - FRAC_BITS;
  localparam int PF_W      = RM_W + 1 + COEF_BITS;

  // register indexes
  localparam logic [IDX_W-1:0] REG_D_ROW0 = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_D_ROW1 = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_D_ROW2 = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_F_ROW0 = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_F_ROW1 = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_F_ROW2 = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_D_EXP  = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_F_EXP  = IDX_W'(7);

  typedef logic signed [62:0] sval_t;
  localparam sval_t SAT_LIM = {1'b0, {62{1'b1}}};
  localparam logic signed [127:0] SAT_LIM_W = 128'(SAT_LIM);

  typedef struct packed {
    logic        [30:0] viscosity;
    logic        [30:0] density;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [30:0] cell_volume;
    logic signed [31:0] diag_in;
    logic signed [31:0] source_x_in;
    logic signed [31:0] source_y_in;
    logic signed [31:0] source_z_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] diag_out;
    logic signed [31:0] source_x_out;
    logic signed [31:0] source_y_out;
    logic signed [31:0] source_z_out;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] x;
    logic [35:0] rem;
    logic [31:0] root;
  } sqrt_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] ph;
    logic [63:0] pl;
  } part_t;

  function automatic sval_t clamp_lim(input logic signed [127:0] v);
    sval_t r;
    if (v > SAT_LIM_W) r = SAT_LIM;
    else if (v < -SAT_LIM_W) r = -SAT_LIM;
    else r = 63'(v);
    return r;
  endfunction

  // left shift saturates, right shift floors
  function automatic sval_t scale_exp(input sval_t v, input logic signed [EXP_W-1:0] e);
    logic signed [127:0] w;
    logic [EXP_W-1:0] sh;
    sval_t r;
    w  = 128'(v);
    sh = ~e + EXP_W'(1);
    if (!e[EXP_W-1]) r = clamp_lim(w <<< e[EXP_W-2:0]);
    else r = v >>> sh;
    return r;
  endfunction

  function automatic logic [61:0] abs62(input sval_t v);
    logic [61:0] r;
    if (v < 0) r = 62'(-v);
    else r = 62'(v);
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic [31:0] r;
    if (v[31]) r = 32'(-v);
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic signed [COEF_BITS-1:0] coef(input logic [ROW_W-1:0] row,
                                                      input int col);
    return row[col*COEF_BITS +: COEF_BITS];
  endfunction

  // magnitude product split into two 31-bit halves of a
  function automatic part_t mul_part(input logic [61:0] a, input logic [32:0] b,
                                     input logic neg);
    part_t p;
    p.neg = neg;
    p.ph  = 64'(a[61:31]) * 64'(b);
    p.pl  = 64'(a[30:0]) * 64'(b);
    return p;
  endfunction

  function automatic sval_t mul_join(input part_t p);
    logic [95:0] full;
    sval_t m;
    full = (96'(p.ph) << 31) + 96'(p.pl);
    if (full > 96'(SAT_LIM)) m = SAT_LIM;
    else m = 63'(full);
    if (p.neg) m = -m;
    return m;
  endfunction

  function automatic sqrt_t sqrt_steps(input sqrt_t s);
    sqrt_t r;
    logic [35:0] rem2;
    logic [35:0] trial;
    r = s;
    for (int k = 0; k < SQ_STEPS; k++) begin
      rem2  = {r.rem[33:0], r.x[63:62]};
      trial = {2'b00, r.root, 2'b01};
      if (rem2 >= trial) begin
        r.rem  = rem2 - trial;
        r.root = {r.root[30:0], 1'b1};
      end else begin
        r.rem  = rem2;
        r.root = {r.root[30:0], 1'b0};
      end
      r.x = r.x << 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/porous_drag_source_update_core.sv
`default_nettype none
// Darcy-Forchheimer drag update per mesh cell, Q16.16 throughout. Fully pipelined: one cell
// enters per clock unless the output stalls; the pipeline depth is set by the 32-bit
// truncating square root of |U|^2 (eight stages, four root bits each) and by the wide
// products, split into 31-bit halves over two stages. Each stage moves on when its successor
// has room, so a stalled output only holds the stages behind it. Coefficient registers must
// be written via the cfg port while no cell is in flight; the user, not the core, ensures it.
module porous_drag_source_update_core
  import pdsu_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_beat_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_beat_t                out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [ROW_W-1:0]    cfg_wdata
);

  localparam int NSTG = 22;
  localparam int SQ0  = 2;
  localparam int SQ1  = SQ0 + 32 / SQ_STEPS - 1;

  logic [ROW_W-1:0]        d_row_r [3];
  logic [ROW_W-1:0]        f_row_r [3];
  logic signed [EXP_W-1:0] d_exp_r;
  logic signed [EXP_W-1:0] f_exp_r;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;
  in_beat_t        beat_r [NSTG-1];

  logic [63:0]            sqa_r [3];
  sval_t                  pd_r  [3][3];
  logic [63:0]            sq_r;
  sval_t                  td_r  [1:12][3][3];
  sqrt_t                  sqs_r [SQ0:SQ1];
  logic [62:0]            prm_r;
  logic signed [PF_W-1:0] pf_r  [3][3];
  sval_t                  tf_r  [3][3];
  sval_t                  cd_r  [3][3];
  sval_t                  cd2_r [3][3];
  sval_t                  t_r;
  sval_t                  m_r   [3][3];
  sval_t                  t2_r;
  part_t                  pp_r  [10];
  sval_t                  term_r[10];
  sval_t                  rs_r  [3];
  logic signed [31:0]     dg_r  [18:20];
  part_t                  sp_r  [3];
  sval_t                  s_r   [3];
  out_beat_t              out_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        d_row_r[i] <= '0;
        f_row_r[i] <= '0;
      end
      d_exp_r <= '0;
      f_exp_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_D_ROW0: d_row_r[0] <= cfg_wdata;
        REG_D_ROW1: d_row_r[1] <= cfg_wdata;
        REG_D_ROW2: d_row_r[2] <= cfg_wdata;
        REG_F_ROW0: f_row_r[0] <= cfg_wdata;
        REG_F_ROW1: f_row_r[1] <= cfg_wdata;
        REG_F_ROW2: f_row_r[2] <= cfg_wdata;
        REG_D_EXP:  d_exp_r    <= cfg_wdata[EXP_W-1:0];
        REG_F_EXP:  f_exp_r    <= cfg_wdata[EXP_W-1:0];
        default:    d_exp_r    <= d_exp_r;
      endcase
    end
  end

  // stage enables, a stage moves on when the next one has room
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) beat_r[0] <= in_data;
    for (int k = 1; k < NSTG - 1; k++) begin
      if (en[k]) beat_r[k] <= beat_r[k-1];
    end
  end

  // squares of |U| components and viscous products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      sqa_r[0] <= 64'(abs32(in_data.vel_x)) * 64'(abs32(in_data.vel_x));
      sqa_r[1] <= 64'(abs32(in_data.vel_y)) * 64'(abs32(in_data.vel_y));
      sqa_r[2] <= 64'(abs32(in_data.vel_z)) * 64'(abs32(in_data.vel_z));
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pd_r[i][j] <= 63'($signed({1'b0, in_data.viscosity}) * coef(d_row_r[i], j));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sq_r <= sqa_r[0] + sqa_r[1] + sqa_r[2];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          td_r[1][i][j] <= scale_exp(pd_r[i][j], d_exp_r);
        end
      end
    end
    for (int k = 2; k <= 12; k++) begin
      if (en[k]) td_r[k] <= td_r[k-1];
    end
  end

  // square root, four root bits per stage
  always_ff @(posedge clk) begin
    if (en[SQ0]) sqs_r[SQ0] <= sqrt_steps('{x: sq_r, rem: '0, root: '0});
    for (int k = SQ0 + 1; k <= SQ1; k++) begin
      if (en[k]) sqs_r[k] <= sqrt_steps(sqs_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) prm_r <= 63'(beat_r[9].density) * 63'(sqs_r[SQ1].root);
  end

  // inertial products from density * |U|
  always_ff @(posedge clk) begin
    if (en[11]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pf_r[i][j] <= $signed({1'b0, prm_r[62:FRAC_BITS]}) * coef(f_row_r[i], j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          tf_r[i][j] <= scale_exp(clamp_lim(128'(pf_r[i][j])), f_exp_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[13]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cd_r[i][j] <= clamp_lim(128'(td_r[12][i][j]) + 128'(tf_r[i][j]));
        end
      end
    end
  end

  // trace
  always_ff @(posedge clk) begin
    if (en[14]) begin
      cd2_r <= cd_r;
      t_r   <= clamp_lim(128'(clamp_lim(128'(cd_r[0][0]) + 128'(cd_r[1][1])))
                         + 128'(cd_r[2][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[15]) begin
      t2_r <= t_r;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (i == j) m_r[i][j] <= clamp_lim(128'(cd2_r[i][j]) - 128'(t_r));
          else m_r[i][j] <= cd2_r[i][j];
        end
      end
    end
  end

  // split products M*U and V*t
  always_ff @(posedge clk) begin
    logic signed [31:0] u;
    if (en[16]) begin
      for (int j = 0; j < 3; j++) begin
        unique case (j)
          0:       u = beat_r[15].vel_x;
          1:       u = beat_r[15].vel_y;
          default: u = beat_r[15].vel_z;
        endcase
        for (int i = 0; i < 3; i++) begin
          pp_r[i*3+j] <= mul_part(abs62(m_r[i][j]),
                                  u[31] ? 33'(-34'(u)) : 33'(u),
                                  m_r[i][j][62] != u[31]);
        end
      end
      pp_r[9] <= mul_part(abs62(t2_r), 33'(beat_r[15].cell_volume), t2_r[62]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[17]) begin
      for (int n = 0; n < 10; n++) begin
        term_r[n] <= mul_join(pp_r[n]) >>> FRAC_BITS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[18]) begin
      for (int i = 0; i < 3; i++) begin
        rs_r[i] <= term_r[i*3] + term_r[i*3+1] + term_r[i*3+2];
      end
      dg_r[18] <= sat32(64'(beat_r[17].diag_in) + 64'(term_r[9]));
    end
    for (int k = 19; k <= 20; k++) begin
      if (en[k]) dg_r[k] <= dg_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[19]) begin
      for (int i = 0; i < 3; i++) begin
        sp_r[i] <= mul_part(abs62(rs_r[i]), 33'(beat_r[18].cell_volume), rs_r[i][62]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[20]) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i] <= mul_join(sp_r[i]) >>> FRAC_BITS;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[21]) begin
      out_r.diag_out     <= dg_r[20];
      out_r.source_x_out <= sat32(64'(beat_r[20].source_x_in) - 64'(s_r[0]));
      out_r.source_y_out <= sat32(64'(beat_r[20].source_y_in) - 64'(s_r[1]));
      out_r.source_z_out <= sat32(64'(beat_r[20].source_z_in) - 64'(s_r[2]));
    end
  end

endmodule
`default_nettype wire

### test/porous_drag_source_update_core_test.sv
`timescale 1ns / 1ps
module porous_drag_source_update_core_test;
  import pdsu_pkg::*;

  typedef logic signed [127:0] wide_t;
  localparam wide_t LIM = wide_t'(SAT_LIM);
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0] cfg_wdata = '0;

  porous_drag_source_update_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the coefficient registers
  logic [ROW_W-1:0] row_q [6];
  logic signed [EXP_W-1:0] d_exp_q, f_exp_q;

  in_beat_t cell_q[$];
  out_beat_t drag_q[$];
  int errors = 0;
  int hold_req = 0;

  function automatic wide_t clip62(input wide_t v);
    wide_t r;
    if (v > LIM) r = LIM;
    else if (v < -LIM) r = -LIM;
    else r = v;
    return r;
  endfunction

  function automatic wide_t pow2_scale(input wide_t v, input logic signed [EXP_W-1:0] e);
    int ei;
    wide_t r;
    ei = e;
    if (ei >= 0) r = clip62(v <<< ei);
    else r = v >>> (-ei);
    return r;
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic wide_t mant(input logic [ROW_W-1:0] row, input int col);
    logic signed [COEF_BITS-1:0] c;
    c = row[col*COEF_BITS +: COEF_BITS];
    return wide_t'(c);
  endfunction

  function automatic logic signed [31:0] clip32(input wide_t v);
    logic signed [31:0] r;
    if (v > 128'sd2147483647) r = 32'sh7fffffff;
    else if (v < -128'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  function automatic out_beat_t drag_update(input in_beat_t c);
    wide_t mu, rho, vol, rm, t, diag, m, r, s, sqw;
    wide_t u [3];
    wide_t src [3];
    wide_t cd [3][3];
    logic [63:0] mag;
    out_beat_t o;
    mu = wide_t'({1'b0, c.viscosity});
    rho = wide_t'({1'b0, c.density});
    vol = wide_t'({1'b0, c.cell_volume});
    u[0] = wide_t'(c.vel_x);
    u[1] = wide_t'(c.vel_y);
    u[2] = wide_t'(c.vel_z);
    src[0] = wide_t'(c.source_x_in);
    src[1] = wide_t'(c.source_y_in);
    src[2] = wide_t'(c.source_z_in);
    sqw = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    mag = root_floor(64'(sqw));
    rm = (rho * wide_t'({64'd0, mag})) >>> FRAC_BITS;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cd[i][j] = clip62(pow2_scale(clip62(mu * mant(row_q[i], j)), d_exp_q) +
                          pow2_scale(clip62(rm * mant(row_q[3+i], j)), f_exp_q));
    t = clip62(clip62(cd[0][0] + cd[1][1]) + cd[2][2]);
    diag = clip62(vol * t) >>> FRAC_BITS;
    o.diag_out = clip32(wide_t'(c.diag_in) + diag);
    for (int i = 0; i < 3; i++) begin
      r = 0;
      for (int j = 0; j < 3; j++) begin
        m = (i == j) ? clip62(cd[i][j] - t) : cd[i][j];
        r = clip62(r + (clip62(m * u[j]) >>> FRAC_BITS));
      end
      s = clip62(vol * r) >>> FRAC_BITS;
      if (i == 0) o.source_x_out = clip32(src[i] - s);
      else if (i == 1) o.source_y_out = clip32(src[i] - s);
      else o.source_z_out = clip32(src[i] - s);
    end
    return o;
  endfunction

  // sender: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        drag_q.push_back(drag_update(in_data));
        void'(cell_q.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cell_q.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= cell_q[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 16);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall pattern, re-chosen when its counter runs out, plus long hold-offs on request
  int rx_mode = 0;
  int rx_cnt = 0;
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_left == 0 && hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (rx_cnt == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_cnt = 64;
    end
    rx_cnt--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= $urandom_range(0, 7) != 0;
        default: out_ready <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  // result checker and watchdog
  int idle_cycles = 0;
  always @(posedge clk) begin
    out_beat_t want;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (out_valid && out_ready) begin
      if (drag_q.size() == 0) begin
        if (errors < 10) $display("unexpected result beat %h", out_data);
        errors++;
      end else begin
        want = drag_q.pop_front();
        if (want.diag_out !== out_data.diag_out ||
            want.source_x_out !== out_data.source_x_out ||
            want.source_y_out !== out_data.source_y_out ||
            want.source_z_out !== out_data.source_z_out) begin
          if (errors < 10)
            $display("mismatch diag %h/%h sx %h/%h sy %h/%h sz %h/%h (exp/act)",
                     want.diag_out, out_data.diag_out, want.source_x_out,
                     out_data.source_x_out, want.source_y_out, out_data.source_y_out,
                     want.source_z_out, out_data.source_z_out);
          errors++;
        end
      end
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] pick32(input bit is_signed);
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = is_signed ? 32'h7fffffff : 32'h7fffffff;
      2: v = is_signed ? 32'h80000000 : 32'h00000001;
      3: v = $urandom_range(0, 1 << 18);
      4: v = -$urandom_range(0, 1 << 18);
      default: v = $urandom;
    endcase
    if (!is_signed) v[31] = 1'b0;
    return v;
  endfunction

  function automatic in_beat_t random_cell();
    in_beat_t c;
    c.viscosity = 31'(pick32(0));
    c.density = 31'(pick32(0));
    c.vel_x = pick32(1);
    c.vel_y = pick32(1);
    c.vel_z = pick32(1);
    c.cell_volume = 31'(pick32(0));
    c.diag_in = pick32(1);
    c.source_x_in = pick32(1);
    c.source_y_in = pick32(1);
    c.source_z_in = pick32(1);
    return c;
  endfunction

  task automatic wait_drained();
    while (cell_q.size() != 0 || in_valid || drag_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_D_EXP) d_exp_q = val[EXP_W-1:0];
    else if (idx == REG_F_EXP) f_exp_q = val[EXP_W-1:0];
    else row_q[idx] = val;
  endtask

  // kind: 0 random, 1 max mantissas, 2 min mantissas, 3 small unit-ish values
  task automatic configure(input int kind, input logic signed [EXP_W-1:0] de,
                           input logic signed [EXP_W-1:0] fe);
    logic [ROW_W-1:0] v;
    logic [COEF_BITS-1:0] mm;
    for (int i = 0; i < 6; i++) begin
      case (kind)
        1: v = {3{21'h0fffff}};
        2: v = {3{21'h100000}};
        3: begin
          for (int j = 0; j < 3; j++) begin
            mm = COEF_BITS'($urandom_range(0, 4096) - 2048);
            v[j*COEF_BITS +: COEF_BITS] = mm;
          end
        end
        default: v = 63'({$urandom, $urandom});
      endcase
      write_reg(REG_D_ROW0 + IDX_W'(i), v);
    end
    write_reg(REG_D_EXP, ROW_W'(de));
    write_reg(REG_F_EXP, ROW_W'(fe));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic directed_cells();
    in_beat_t c;
    for (int k = 0; k < 20; k++) begin
      c = random_cell();
      case (k % 5)
        0: c = '0;
        1: begin
          c.vel_x = 32'h80000000; c.vel_y = 32'h80000000; c.vel_z = 32'h80000000;
          c.viscosity = '1; c.density = '1; c.cell_volume = '1;
        end
        2: begin
          c.vel_x = 32'h7fffffff; c.vel_y = 32'h7fffffff; c.vel_z = 32'h7fffffff;
          c.diag_in = 32'h7fffffff; c.source_x_in = 32'h80000000;
        end
        3: begin
          c.vel_x = 32'h00010000; c.vel_y = -32'sh00010000; c.vel_z = 0;
          c.cell_volume = 31'h10000; c.viscosity = 31'h10000; c.density = 31'h10000;
        end
        default: ;
      endcase
      cell_q.push_back(c);
    end
  endtask

  initial begin
    for (int i = 0; i < 6; i++) row_q[i] = '0;
    d_exp_q = '0;
    f_exp_q = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset coefficients first: drag is zero
    directed_cells();
    for (int n = 0; n < 60; n++) cell_q.push_back(random_cell());
    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      case (ph)
        0: configure(3, -6'sd16, -6'sd16);
        1: configure(1, 6'sd31, 6'sd31);
        2: configure(2, -6'sd32, -6'sd32);
        3: configure(1, -6'sd32, 6'sd0);
        4: configure(2, 6'sd31, -6'sd20);
        default: configure(ph == 5 ? 3 : 0,
                           EXP_W'($urandom_range(0, 63)), EXP_W'($urandom_range(0, 63)));
      endcase
      if (ph < 2) directed_cells();
      if (ph == 2) begin
        // fill the pipe behind a stalled output
        hold_req++;
        for (int n = 0; n < 120; n++) cell_q.push_back(random_cell());
      end
      for (int n = 0; n < 170; n++) cell_q.push_back(random_cell());
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
